// ===== hdl/mlp_pkg.sv =====
// mlp_pkg: shared types, widths, codes and helpers of the one-hidden-layer
// perceptron trainer. Used by mlp_mac, mlp_sig and mlp_one_hidden_layer_train.
// No dependencies.
package mlp_pkg;

  localparam int DEF_MAX_INPUTS     = 8;
  localparam int DEF_MAX_HIDDEN     = 16;
  localparam int DEF_MAX_OUTPUTS    = 4;
  localparam int DEF_SIGMOID_ENTRIES = 256;

  localparam int A_W   = 28;  // multiplier operand a, signed
  localparam int B_W   = 17;  // multiplier operand b, signed
  localparam int MUL_W = A_W + B_W;
  localparam int ACC_W = 40;
  localparam int SAT_W = 48;

  localparam logic [3:0]  RST_INPUT_COUNT  = 4'd5;
  localparam logic [4:0]  RST_HIDDEN_COUNT = 5'd8;
  localparam logic [2:0]  RST_OUTPUT_COUNT = 3'd1;
  localparam logic [12:0] RST_LEARN_RATE   = 13'd410;

  typedef enum logic [2:0] {
    OP_INPUT  = 3'd0,
    OP_TARGET = 3'd1,
    OP_PARAM  = 3'd2,
    OP_INFER  = 3'd3,
    OP_TRAIN  = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    REG_INPUT_COUNT  = 2'd0,
    REG_HIDDEN_COUNT = 2'd1,
    REG_OUTPUT_COUNT = 2'd2,
    REG_LEARN_RATE   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } mac_ctl_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [7:0]         index;
    logic signed [15:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]  out_index;
    logic [12:0] out_value;
    logic        last;
  } out_t;

  function automatic logic signed [15:0] sat16(input logic signed [SAT_W-1:0] v);
    logic signed [15:0] r;
    if (v > SAT_W'(32767))
      r = 16'sh7fff;
    else if (v < -SAT_W'(32768))
      r = 16'sh8000;
    else
      r = v[15:0];
    return r;
  endfunction

  // restoring long division, only evaluated at elaboration
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q   = 0;
    rem = 0;
    for (int j = 63; j >= 0; j--) begin
      rem = {rem[62:0], n[j]};
      if (rem >= d) begin
        rem  = rem - d;
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // sigmoid table entry k of n over [-8,8), built at elaboration
  function automatic logic [12:0] sig_entry(input int k, input int n);
    longint          sum;
    longint          term;
    longint          num;
    longint unsigned base;
    longint unsigned one;
    longint unsigned e;
    longint unsigned b;
    longint unsigned m;
    longint unsigned den;
    longint unsigned r;
    sum  = 0;
    term = longint'(1) << 62;
    for (int j = 0; j < 40; j++) begin
      if (term > 0) begin
        if (j > 0)
          term = longint'(udiv64(longint'(term), longint'(n) * longint'(j)));
        sum = (j[0]) ? sum - term : sum + term;
      end
    end
    one  = longint'(1) << 31;
    base = (longint'(sum) + (longint'(1) << 30)) >> 31;
    num  = 16 * longint'(k) - 8 * longint'(n);
    m    = (num < 0) ? -num : num;
    e    = one;
    b    = base;
    for (int j = 0; j < 20; j++) begin
      if (m[j]) e = (e * b + (longint'(1) << 30)) >> 31;
      b = (b * b + (longint'(1) << 30)) >> 31;
    end
    den = one + e;
    if (num >= 0)
      r = udiv64(64'd4096 * one + (den >> 1), den);
    else
      r = udiv64(64'd4096 * e + (den >> 1), den);
    return r[12:0];
  endfunction

endpackage

// ===== hdl/mlp_one_hidden_layer_train.sv =====
// mlp_one_hidden_layer_train: top level, sequencer, parameter memories and
// vector stores. Depends on mlp_pkg, mlp_mac, mlp_sig.
//
//   channel | ports                         | handshake
//   input   | start, busy, in_data          | taken when start & !busy
//   result  | out_valid, out_data           | one-cycle strobe, no stall
//   config  | cfg_we, cfg_index, cfg_wdata  | written when cfg_we
//
// load beats (input, target, parameter word) are stored directly; busy stays low.
// a run walks every product through the one mac, and busy is high for the
// whole run; results leave as one-cycle strobes.
// rst_n is synchronous and clears control and the registers only; stores
// are not cleared.
module mlp_one_hidden_layer_train #(
  parameter int MAX_INPUTS      = mlp_pkg::DEF_MAX_INPUTS,
  parameter int MAX_HIDDEN      = mlp_pkg::DEF_MAX_HIDDEN,
  parameter int MAX_OUTPUTS     = mlp_pkg::DEF_MAX_OUTPUTS,
  parameter int SIGMOID_ENTRIES = mlp_pkg::DEF_SIGMOID_ENTRIES
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  mlp_pkg::in_t  in_data,
  output logic          out_valid,
  output mlp_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [12:0]   cfg_wdata
);
  import mlp_pkg::*;

  localparam int IW      = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int HW      = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int OW      = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int WIH_N   = MAX_HIDDEN * MAX_INPUTS;
  localparam int WHO_N   = MAX_OUTPUTS * MAX_HIDDEN;
  localparam int WIH_AW  = (WIH_N > 1) ? $clog2(WIH_N) : 1;
  localparam int WHO_AW  = (WHO_N > 1) ? $clog2(WHO_N) : 1;
  localparam int WHO_BASE  = WIH_N;
  localparam int BH_BASE   = WHO_BASE + WHO_N;
  localparam int BO_BASE   = BH_BASE + MAX_HIDDEN;
  localparam int PARAM_END = BO_BASE + MAX_OUTPUTS;

  typedef enum logic [27:0] {
    S_IDLE    = 28'd1 << 0,
    S_FH_RD   = 28'd1 << 1,
    S_FH_MUL  = 28'd1 << 2,
    S_FH_SUM  = 28'd1 << 3,
    S_FH_ACT  = 28'd1 << 4,
    S_FO_RD   = 28'd1 << 5,
    S_FO_MUL  = 28'd1 << 6,
    S_FO_SUM  = 28'd1 << 7,
    S_FO_ACT  = 28'd1 << 8,
    S_BO_D    = 28'd1 << 9,
    S_BO_E    = 28'd1 << 10,
    S_BO_G1   = 28'd1 << 11,
    S_BO_G2   = 28'd1 << 12,
    S_BO_RD   = 28'd1 << 13,
    S_BO_MUL  = 28'd1 << 14,
    S_BO_WR   = 28'd1 << 15,
    S_BO_BIAS = 28'd1 << 16,
    S_BH_RD   = 28'd1 << 17,
    S_BH_MUL  = 28'd1 << 18,
    S_BH_SUM  = 28'd1 << 19,
    S_BH_E    = 28'd1 << 20,
    S_BH_D    = 28'd1 << 21,
    S_BH_G1   = 28'd1 << 22,
    S_BH_G2   = 28'd1 << 23,
    S_BI_RD   = 28'd1 << 24,
    S_BI_MUL  = 28'd1 << 25,
    S_BI_WR   = 28'd1 << 26,
    S_BH_BIAS = 28'd1 << 27
  } state_t;

  state_t state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [HW-1:0] h_r, h_nxt;
  logic [OW-1:0] o_r, o_nxt;
  logic          train_r, train_nxt;

  logic [3:0]  in_cnt_r;
  logic [4:0]  hid_cnt_r;
  logic [2:0]  out_cnt_r;
  logic [12:0] lr_r;

  logic signed [15:0] x_r   [MAX_INPUTS];
  logic signed [15:0] t_r   [MAX_OUTPUTS];
  logic [12:0]        ha_r  [MAX_HIDDEN];
  logic [12:0]        oa_r  [MAX_OUTPUTS];
  logic signed [15:0] err_r [MAX_OUTPUTS];
  logic signed [15:0] bh_r  [MAX_HIDDEN];
  logic signed [15:0] bo_r  [MAX_OUTPUTS];
  logic signed [15:0] wih_mem [WIH_N];
  logic signed [15:0] who_mem [WHO_N];
  logic signed [15:0] wih_q_r, who_q_r;
  logic signed [15:0] g_r, e_r;

  logic          out_valid_r;
  out_t          out_data_r;

  logic [IW-1:0] ilast;
  logic [HW-1:0] hlast;
  logic [OW-1:0] olast;
  int            ni, nh, no;

  logic          accept;
  int            pidx;
  logic [WIH_AW-1:0] wih_ra, wih_wa;
  logic [WHO_AW-1:0] who_ra, who_wa;
  logic              wih_we, who_we;
  logic signed [15:0] wih_wd, who_wd;

  mac_ctl_t                 mac_ctl;
  logic signed [A_W-1:0]    mac_a;
  logic signed [B_W-1:0]    mac_b;
  logic signed [ACC_W-1:0]  acc_init;
  logic signed [MUL_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [12:0]              sig_y;

  logic signed [15:0] x_cur, t_cur, bh_cur, bo_cur, err_cur;
  logic [12:0]        ha_cur, oa_cur;
  logic signed [15:0] err_new, e_new, g_new, upd_w;
  logic signed [B_W-1:0] ha_comp, oa_comp;

  mlp_mac u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .a        (mac_a),
    .b        (mac_b),
    .acc_init (acc_init),
    .prod_r   (prod_r),
    .acc_r    (acc_r)
  );

  mlp_sig #(.SIGMOID_ENTRIES(SIGMOID_ENTRIES)) u_sig (
    .acc (acc_r),
    .y   (sig_y)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // node counts clamped to [1, max]
  always_comb begin
    ni = (in_cnt_r == 4'd0) ? 1 : ((int'(in_cnt_r) > MAX_INPUTS) ? MAX_INPUTS
                                                                  : int'(in_cnt_r));
    nh = (hid_cnt_r == 5'd0) ? 1 : ((int'(hid_cnt_r) > MAX_HIDDEN) ? MAX_HIDDEN
                                                                    : int'(hid_cnt_r));
    no = (out_cnt_r == 3'd0) ? 1 : ((int'(out_cnt_r) > MAX_OUTPUTS) ? MAX_OUTPUTS
                                                                     : int'(out_cnt_r));
    ilast = IW'(ni - 1);
    hlast = HW'(nh - 1);
    olast = OW'(no - 1);
  end

  always_comb begin
    x_cur   = x_r[i_r];
    t_cur   = t_r[o_r];
    bh_cur  = bh_r[h_r];
    bo_cur  = bo_r[o_r];
    err_cur = err_r[o_r];
    ha_cur  = ha_r[h_r];
    oa_cur  = oa_r[o_r];
    ha_comp = $signed(B_W'(4096)) - $signed(B_W'(ha_cur));
    oa_comp = $signed(B_W'(4096)) - $signed(B_W'(oa_cur));
    err_new = sat16(SAT_W'(t_cur) - SAT_W'($signed({1'b0, oa_cur})));
    e_new   = sat16(SAT_W'(acc_r >>> 12));
    g_new   = sat16(SAT_W'(prod_r >>> 24));
    upd_w   = sat16(((state_r == S_BO_WR) ? SAT_W'(who_q_r) : SAT_W'(wih_q_r))
                    + SAT_W'(prod_r >>> 12));
    wih_ra  = WIH_AW'(int'(h_r) * MAX_INPUTS + int'(i_r));
    who_ra  = WHO_AW'(int'(o_r) * MAX_HIDDEN + int'(h_r));
    pidx    = int'(in_data.index);
  end

  // shared unit operand selection
  always_comb begin
    mac_ctl.mul_en = 1'b0;
    mac_ctl.acc_op = ACC_HOLD;
    mac_a    = '0;
    mac_b    = '0;
    acc_init = '0;
    case (state_r)
      S_FH_RD: begin
        mac_ctl.acc_op = (i_r == '0) ? ACC_LOAD : ACC_ADD;
        acc_init = ACC_W'(bh_cur) <<< 12;
      end
      S_FO_RD: begin
        mac_ctl.acc_op = (h_r == '0) ? ACC_LOAD : ACC_ADD;
        acc_init = ACC_W'(bo_cur) <<< 12;
      end
      S_BH_RD: begin
        mac_ctl.acc_op = (o_r == '0) ? ACC_LOAD : ACC_ADD;
      end
      S_FH_SUM, S_FO_SUM, S_BH_SUM: begin
        mac_ctl.acc_op = ACC_ADD;
      end
      S_FH_MUL: begin
        mac_ctl.mul_en = 1'b1;
        mac_a = A_W'(wih_q_r);
        mac_b = B_W'(x_cur);
      end
      S_FO_MUL: begin
        mac_ctl.mul_en = 1'b1;
        mac_a = A_W'(who_q_r);
        mac_b = $signed(B_W'(ha_cur));
      end
      S_BO_D: begin
        mac_ctl.mul_en = 1'b1;
        mac_a = $signed(A_W'(oa_cur));
        mac_b = oa_comp;
      end
      S_BO_E: begin
        mac_ctl.mul_en = 1'b1;
        mac_a = A_W'(prod_r >>> 12);
        mac_b = B_W'(err_new);
      end
      S_BO_G1, S_BH_G1: begin
        mac_ctl.mul_en = 1'b1;
        mac_a = prod_r[A_W-1:0];
        mac_b = $signed(B_W'(lr_r));
      end
      S_BO_MUL: begin
        mac_ctl.mul_en = 1'b1;
        mac_a = A_W'(g_r);
        mac_b = $signed(B_W'(ha_cur));
      end
      S_BH_MUL: begin
        mac_ctl.mul_en = 1'b1;
        mac_a = A_W'(who_q_r);
        mac_b = B_W'(err_cur);
      end
      S_BH_E: begin
        mac_ctl.mul_en = 1'b1;
        mac_a = $signed(A_W'(ha_cur));
        mac_b = ha_comp;
      end
      S_BH_D: begin
        mac_ctl.mul_en = 1'b1;
        mac_a = A_W'(prod_r >>> 12);
        mac_b = B_W'(e_r);
      end
      S_BI_MUL: begin
        mac_ctl.mul_en = 1'b1;
        mac_a = A_W'(g_r);
        mac_b = B_W'(x_cur);
      end
      default: begin
        mac_ctl.mul_en = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    h_nxt     = h_r;
    o_nxt     = o_r;
    train_nxt = train_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_data.opcode == OP_INFER || in_data.opcode == OP_TRAIN)) begin
          train_nxt = (in_data.opcode == OP_TRAIN);
          i_nxt = '0;
          h_nxt = '0;
          o_nxt = '0;
          state_nxt = S_FH_RD;
        end
      end
      S_FH_RD: state_nxt = S_FH_MUL;
      S_FH_MUL: begin
        if (i_r == ilast) state_nxt = S_FH_SUM;
        else begin
          i_nxt = IW'(i_r + 1'b1);
          state_nxt = S_FH_RD;
        end
      end
      S_FH_SUM: state_nxt = S_FH_ACT;
      S_FH_ACT: begin
        i_nxt = '0;
        if (h_r == hlast) begin
          h_nxt = '0;
          o_nxt = '0;
          state_nxt = S_FO_RD;
        end else begin
          h_nxt = HW'(h_r + 1'b1);
          state_nxt = S_FH_RD;
        end
      end
      S_FO_RD: state_nxt = S_FO_MUL;
      S_FO_MUL: begin
        if (h_r == hlast) state_nxt = S_FO_SUM;
        else begin
          h_nxt = HW'(h_r + 1'b1);
          state_nxt = S_FO_RD;
        end
      end
      S_FO_SUM: state_nxt = S_FO_ACT;
      S_FO_ACT: begin
        h_nxt = '0;
        if (o_r == olast) begin
          o_nxt = '0;
          state_nxt = train_r ? S_BO_D : S_IDLE;
        end else begin
          o_nxt = OW'(o_r + 1'b1);
          state_nxt = S_FO_RD;
        end
      end
      S_BO_D:  state_nxt = S_BO_E;
      S_BO_E:  state_nxt = S_BO_G1;
      S_BO_G1: state_nxt = S_BO_G2;
      S_BO_G2: begin
        h_nxt = '0;
        state_nxt = S_BO_RD;
      end
      S_BO_RD:  state_nxt = S_BO_MUL;
      S_BO_MUL: state_nxt = S_BO_WR;
      S_BO_WR: begin
        if (h_r == hlast) state_nxt = S_BO_BIAS;
        else begin
          h_nxt = HW'(h_r + 1'b1);
          state_nxt = S_BO_RD;
        end
      end
      S_BO_BIAS: begin
        if (o_r == olast) begin
          o_nxt = '0;
          h_nxt = '0;
          state_nxt = S_BH_RD;
        end else begin
          o_nxt = OW'(o_r + 1'b1);
          state_nxt = S_BO_D;
        end
      end
      S_BH_RD: state_nxt = S_BH_MUL;
      S_BH_MUL: begin
        if (o_r == olast) state_nxt = S_BH_SUM;
        else begin
          o_nxt = OW'(o_r + 1'b1);
          state_nxt = S_BH_RD;
        end
      end
      S_BH_SUM: begin
        o_nxt = '0;
        state_nxt = S_BH_E;
      end
      S_BH_E:  state_nxt = S_BH_D;
      S_BH_D:  state_nxt = S_BH_G1;
      S_BH_G1: state_nxt = S_BH_G2;
      S_BH_G2: begin
        i_nxt = '0;
        state_nxt = S_BI_RD;
      end
      S_BI_RD:  state_nxt = S_BI_MUL;
      S_BI_MUL: state_nxt = S_BI_WR;
      S_BI_WR: begin
        if (i_r == ilast) state_nxt = S_BH_BIAS;
        else begin
          i_nxt = IW'(i_r + 1'b1);
          state_nxt = S_BI_RD;
        end
      end
      S_BH_BIAS: begin
        o_nxt = '0;
        i_nxt = '0;
        if (h_r == hlast) state_nxt = S_IDLE;
        else begin
          h_nxt = HW'(h_r + 1'b1);
          state_nxt = S_BH_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      h_r         <= '0;
      o_r         <= '0;
      train_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      h_r         <= h_nxt;
      o_r         <= o_nxt;
      train_r     <= train_nxt;
      out_valid_r <= (state_r == S_FO_ACT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r  <= RST_INPUT_COUNT;
      hid_cnt_r <= RST_HIDDEN_COUNT;
      out_cnt_r <= RST_OUTPUT_COUNT;
      lr_r      <= RST_LEARN_RATE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INPUT_COUNT:  in_cnt_r  <= cfg_wdata[3:0];
        REG_HIDDEN_COUNT: hid_cnt_r <= cfg_wdata[4:0];
        REG_OUTPUT_COUNT: out_cnt_r <= cfg_wdata[2:0];
        REG_LEARN_RATE:   lr_r      <= cfg_wdata;
        default:          lr_r      <= lr_r;
      endcase
    end
  end

  // memory write ports: parameter loads when idle, weight updates in training
  always_comb begin
    wih_we = 1'b0;
    who_we = 1'b0;
    wih_wa = wih_ra;
    who_wa = who_ra;
    wih_wd = upd_w;
    who_wd = upd_w;
    if (state_r == S_BI_WR) begin
      wih_we = 1'b1;
    end else if (state_r == S_BO_WR) begin
      who_we = 1'b1;
    end else if (accept && in_data.opcode == OP_PARAM) begin
      wih_wd = in_data.value;
      who_wd = in_data.value;
      if (pidx < WHO_BASE) begin
        wih_we = 1'b1;
        wih_wa = WIH_AW'(pidx);
      end else if (pidx < BH_BASE) begin
        who_we = 1'b1;
        who_wa = WHO_AW'(pidx - WHO_BASE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wih_we) wih_mem[wih_wa] <= wih_wd;
    wih_q_r <= wih_mem[wih_ra];
  end

  always_ff @(posedge clk) begin
    if (who_we) who_mem[who_wa] <= who_wd;
    who_q_r <= who_mem[who_ra];
  end

  // vector stores, biases and step registers
  always_ff @(posedge clk) begin
    if (accept) begin
      case (in_data.opcode)
        OP_INPUT: begin
          if (pidx < MAX_INPUTS) x_r[IW'(pidx)] <= in_data.value;
        end
        OP_TARGET: begin
          if (pidx < MAX_OUTPUTS) t_r[OW'(pidx)] <= in_data.value;
        end
        OP_PARAM: begin
          if (pidx >= BH_BASE && pidx < BO_BASE)
            bh_r[HW'(pidx - BH_BASE)] <= in_data.value;
          else if (pidx >= BO_BASE && pidx < PARAM_END)
            bo_r[OW'(pidx - BO_BASE)] <= in_data.value;
        end
        default: begin
        end
      endcase
    end
    case (state_r)
      S_FH_ACT: ha_r[h_r] <= sig_y;
      S_FO_ACT: begin
        oa_r[o_r] <= sig_y;
        out_data_r.out_index <= 2'(o_r);
        out_data_r.out_value <= sig_y;
        out_data_r.last      <= (o_r == olast);
      end
      S_BO_E:    err_r[o_r] <= err_new;
      S_BO_G2,
      S_BH_G2:   g_r <= g_new;
      S_BO_BIAS: bo_r[o_r] <= sat16(SAT_W'(bo_cur) + SAT_W'(g_r));
      S_BH_E:    e_r <= e_new;
      S_BH_BIAS: bh_r[h_r] <= sat16(SAT_W'(bh_cur) + SAT_W'(g_r));
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/mlp_mac.sv =====
// mlp_mac: the shared signed multiplier with registered product and the
// accumulator behind it. Depends on mlp_pkg.
module mlp_mac (
  input  logic                             clk,
  input  mlp_pkg::mac_ctl_t                ctl,
  input  logic signed [mlp_pkg::A_W-1:0]   a,
  input  logic signed [mlp_pkg::B_W-1:0]   b,
  input  logic signed [mlp_pkg::ACC_W-1:0] acc_init,
  output logic signed [mlp_pkg::MUL_W-1:0] prod_r,
  output logic signed [mlp_pkg::ACC_W-1:0] acc_r
);
  import mlp_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= MUL_W'(a) * MUL_W'(b);
    end
    case (ctl.acc_op)
      ACC_LOAD: acc_r <= acc_init;
      ACC_ADD:  acc_r <= acc_r + prod_r[ACC_W-1:0];
      default:  acc_r <= acc_r;
    endcase
  end

endmodule

// ===== hdl/mlp_sig.sv =====
// mlp_sig: net sum to sigmoid: floor by 4096, saturate to 16 bits, table
// lookup. Depends on mlp_pkg (sat16, sig_entry).
module mlp_sig #(
  parameter int SIGMOID_ENTRIES = mlp_pkg::DEF_SIGMOID_ENTRIES
) (
  input  logic signed [mlp_pkg::ACC_W-1:0] acc,
  output logic [12:0]                      y
);
  import mlp_pkg::*;

  localparam int TW = $clog2(SIGMOID_ENTRIES);
  localparam int PW = 16 + TW + 1;

  logic [12:0]        tab [SIGMOID_ENTRIES];
  logic signed [15:0] p;
  logic [15:0]        u;
  logic [PW-1:0]      scaled;
  logic [TW-1:0]      idx;

  for (genvar k = 0; k < SIGMOID_ENTRIES; k++) begin : g_tab
    localparam logic [12:0] ENTRY = sig_entry(k, SIGMOID_ENTRIES);
    assign tab[k] = ENTRY;
  end

  always_comb begin
    p      = sat16(SAT_W'(acc >>> 12));
    u      = {~p[15], p[14:0]};
    scaled = PW'(u) * PW'(SIGMOID_ENTRIES);
    idx    = scaled[16 +: TW];
    y      = tab[idx];
  end

endmodule
